/* design/bbj_pkg.sv */
`default_nettype none

package bbj_pkg;

	localparam int MEM_ADDR_BITS = 24;
	localparam int MEM_DEPTH = 1 << MEM_ADDR_BITS;
	localparam int ADDR_W = 25;
	localparam int CNT_W = 17;

	localparam logic [CNT_W-1:0] FRAME_MAX = 17'h10000;
	localparam logic [1:0] LAST_WORD = 2'd3;
	localparam logic [1:0] LAST_BYTE = 2'd1;

	localparam logic [ADDR_W-1:0] ADDR_KEY_HI = 25'd0;
	localparam logic [ADDR_W-1:0] ADDR_KEY_LO = 25'd1;
	localparam logic [ADDR_W-1:0] ADDR_PC = 25'd2;
	localparam logic [ADDR_W-1:0] ADDR_PAGES = 25'd5;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FRAME = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_KEY_LO,
		ST_FETCH
	} state_t;

	typedef enum logic [2:0] {
		PH_HOST,
		PH_PAGE,
		PH_PC,
		PH_SRC,
		PH_DST,
		PH_BYTE,
		PH_NEXT
	} phase_t;

	function automatic logic out_of_range(input logic [ADDR_W-1:0] a);
		return (a >> MEM_ADDR_BITS) != '0;
	endfunction

endpackage

`default_nettype wire

/* design/bbj_ram.sv */
`default_nettype none

module bbj_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* design/bytebytejump_frame_engine_unit.sv */
`default_nettype none

// ByteByteJump frame engine over a simple dual-port byte memory (one write and
// one read per cycle, registered read). After reset the memory is zeroed by a
// clearing pass over all 2^MEM_ADDR_BITS addresses (16777216 at 24 bits) during
// which busy stays high; configuration writes are taken at any time. A host
// write or a no-op then fetches the page word, a host read fetches its byte and
// then the page word, and a frame writes the two key bytes, fetches the PC word,
// then per instruction three 3-byte words and one byte, serialized on the read
// port, then the page word (65536 instructions by default). Every op returns one
// result beat on done, valid for one cycle only; the receiver cannot stall it.

module bytebytejump_frame_engine_unit
	import bbj_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  op,
	input  wire logic [23:0] address,
	input  wire logic [7:0]  write_data,
	input  wire logic [15:0] keys,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [16:0] instructions_per_frame,
	output logic             done,
	output logic [7:0]       read_data,
	output logic [7:0]       video_page,
	output logic [15:0]      audio_page
);

	state_t st_q, st_d;
	phase_t phase_q, phase_d;
	logic [1:0] k_q, k_d;
	logic [1:0] last_q, last_d;
	logic [ADDR_W-1:0] base_q, base_d;
	logic [23:0] word_q, word_d;
	logic [23:0] pc_q, pc_d;
	logic [23:0] src_q, src_d;
	logic [23:0] dst_q, dst_d;
	logic [CNT_W-1:0] left_q, left_d;
	logic [CNT_W-1:0] ipf_q;
	logic [CNT_W-1:0] frame_n;
	logic [MEM_ADDR_BITS-1:0] clr_q;
	logic [15:0] keys_q, keys_d;
	logic [7:0] rdata_q, rdata_d;
	logic done_d;
	logic [7:0] video_d;
	logic [15:0] audio_d;
	logic oob_s1;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0] ram_rdata;
	logic [7:0] rbyte;
	logic [23:0] w;
	logic ram_we;
	logic [MEM_ADDR_BITS-1:0] ram_waddr;
	logic [7:0] ram_wdata;

	assign busy = st_q != ST_IDLE;
	assign cfg_ready = 1'b1;
	assign frame_n = (ipf_q > FRAME_MAX) ? FRAME_MAX : ipf_q;
	assign rd_addr = base_q + ADDR_W'(k_q);
	assign rbyte = oob_s1 ? 8'd0 : ram_rdata;
	assign w = {word_q[15:0], rbyte};

	bbj_ram #(
		.WIDTH(8),
		.DEPTH(MEM_DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr[MEM_ADDR_BITS-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		st_d = st_q;
		phase_d = phase_q;
		k_d = k_q;
		last_d = last_q;
		base_d = base_q;
		word_d = word_q;
		pc_d = pc_q;
		src_d = src_q;
		dst_d = dst_q;
		left_d = left_q;
		keys_d = keys_q;
		rdata_d = rdata_q;
		done_d = 1'b0;
		video_d = video_page;
		audio_d = audio_page;
		ram_we = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		unique case (st_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				if (&clr_q) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					keys_d = keys;
					rdata_d = 8'd0;
					k_d = 2'd0;
					last_d = LAST_WORD;
					base_d = ADDR_PAGES;
					phase_d = PH_PAGE;
					st_d = ST_FETCH;
					unique case (op_t'(op))
						OP_WRITE: begin
							ram_we = !out_of_range({1'b0, address});
							ram_waddr = address[MEM_ADDR_BITS-1:0];
							ram_wdata = write_data;
						end
						OP_READ: begin
							base_d = {1'b0, address};
							last_d = LAST_BYTE;
							phase_d = PH_HOST;
						end
						OP_FRAME: begin
							ram_we = 1'b1;
							ram_waddr = ADDR_KEY_HI[MEM_ADDR_BITS-1:0];
							ram_wdata = keys[15:8];
							st_d = ST_KEY_LO;
						end
						OP_NOP: begin
						end
					endcase
				end
			end
			ST_KEY_LO: begin
				ram_we = 1'b1;
				ram_waddr = ADDR_KEY_LO[MEM_ADDR_BITS-1:0];
				ram_wdata = keys_q[7:0];
				base_d = ADDR_PC;
				last_d = LAST_WORD;
				k_d = 2'd0;
				phase_d = PH_PC;
				st_d = ST_FETCH;
			end
			ST_FETCH: begin
				k_d = k_q + 2'd1;
				if (k_q != 2'd0) begin
					word_d = w;
				end
				if (k_q == last_q) begin
					k_d = 2'd0;
					last_d = LAST_WORD;
					unique case (phase_q)
						PH_HOST: begin
							rdata_d = w[7:0];
							base_d = ADDR_PAGES;
							phase_d = PH_PAGE;
						end
						PH_PAGE: begin
							video_d = w[23:16];
							audio_d = w[15:0];
							done_d = 1'b1;
							st_d = ST_IDLE;
						end
						PH_PC: begin
							pc_d = w;
							left_d = frame_n;
							if (frame_n == '0) begin
								base_d = ADDR_PAGES;
								phase_d = PH_PAGE;
							end else begin
								base_d = {1'b0, w};
								phase_d = PH_SRC;
							end
						end
						PH_SRC: begin
							src_d = w;
							base_d = {1'b0, pc_q} + ADDR_W'(3);
							phase_d = PH_DST;
						end
						PH_DST: begin
							dst_d = w;
							base_d = {1'b0, src_q};
							last_d = LAST_BYTE;
							phase_d = PH_BYTE;
						end
						PH_BYTE: begin
							ram_we = !out_of_range({1'b0, dst_q});
							ram_waddr = dst_q[MEM_ADDR_BITS-1:0];
							ram_wdata = w[7:0];
							base_d = {1'b0, pc_q} + ADDR_W'(6);
							phase_d = PH_NEXT;
						end
						PH_NEXT: begin
							pc_d = w;
							left_d = left_q - CNT_W'(1);
							if (left_q == CNT_W'(1)) begin
								base_d = ADDR_PAGES;
								phase_d = PH_PAGE;
							end else begin
								base_d = {1'b0, w};
								phase_d = PH_SRC;
							end
						end
						default: begin
							st_d = ST_IDLE;
						end
					endcase
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			k_q <= '0;
			last_q <= LAST_WORD;
			phase_q <= PH_PAGE;
			left_q <= '0;
			pc_q <= '0;
			ipf_q <= FRAME_MAX;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + MEM_ADDR_BITS'(1);
			end
			k_q <= k_d;
			last_q <= last_d;
			phase_q <= phase_d;
			left_q <= left_d;
			pc_q <= pc_d;
			if (cfg_valid && cfg_ready) begin
				ipf_q <= instructions_per_frame;
			end
			done <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		word_q <= word_d;
		src_q <= src_d;
		dst_q <= dst_d;
		keys_q <= keys_d;
		rdata_q <= rdata_d;
		video_page <= video_d;
		audio_page <= audio_d;
		oob_s1 <= out_of_range(rd_addr);
		if (done_d) begin
			read_data <= rdata_q;
		end
	end

`ifndef ASSERT_OFF
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat outside idle");

	a_no_write_on_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FETCH && k_q != last_q) |-> !ram_we)
		else $error("memory write during word fetch");

	a_fetch_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FETCH) |-> (k_q <= last_q))
		else $error("fetch counter past last byte");

	a_left_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FETCH && (phase_q == PH_SRC || phase_q == PH_NEXT)) |-> (left_q != '0))
		else $error("instruction run with no count left");
`endif

endmodule

`default_nettype wire

/* tb/sv/tb_bytebytejump_frame_engine_unit.sv */
`timescale 1ns / 1ps

import bbj_pkg::*;

typedef struct packed {
	logic [7:0]  read_data;
	logic [7:0]  video_page;
	logic [15:0] audio_page;
} page_beat_t;

class vm_page_tracker;
	bit [7:0] mem_image [int unsigned];
	bit [16:0] frame_len;
	page_beat_t pending_pages [$];
	int unsigned mismatches;
	int unsigned beats;
	longint unsigned steps_run;

	function new();
		frame_len = FRAME_MAX;
		mismatches = 0;
		beats = 0;
		steps_run = 0;
	endfunction

	// addresses past the top read as zero
	function bit [7:0] peek(bit [24:0] a);
		if (a[24] || !mem_image.exists(a))
			return 8'h00;
		return mem_image[a];
	endfunction

	function void poke(bit [24:0] a, bit [7:0] v);
		if (!a[24])
			mem_image[a] = v;
	endfunction

	function bit [23:0] word_at(bit [24:0] a);
		return {peek(a), peek(a + 25'd1), peek(a + 25'd2)};
	endfunction

	function void run_frame(bit [15:0] key_bits);
		bit [16:0] left;
		bit [23:0] pc;
		bit [23:0] src;
		bit [23:0] dst;
		left = (frame_len > FRAME_MAX) ? FRAME_MAX : frame_len;
		poke(25'd0, key_bits[15:8]);
		poke(25'd1, key_bits[7:0]);
		pc = word_at(25'd2);
		while (left != 0) begin
			src = word_at({1'b0, pc});
			dst = word_at({1'b0, pc} + 25'd3);
			poke({1'b0, dst}, peek({1'b0, src}));
			pc = word_at({1'b0, pc} + 25'd6);
			left--;
			steps_run++;
		end
	endfunction

	function void note_op(op_t o, bit [23:0] a, bit [7:0] d, bit [15:0] k);
		page_beat_t exp_beat;
		exp_beat.read_data = 8'h00;
		case (o)
			OP_WRITE: poke({1'b0, a}, d);
			OP_READ: exp_beat.read_data = peek({1'b0, a});
			OP_FRAME: run_frame(k);
			default: ;
		endcase
		exp_beat.video_page = peek(25'd5);
		exp_beat.audio_page = {peek(25'd6), peek(25'd7)};
		pending_pages.push_back(exp_beat);
	endfunction

	function void check_beat(logic [7:0] rd, logic [7:0] vp, logic [15:0] ap);
		page_beat_t exp_beat;
		beats++;
		if (pending_pages.size() == 0) begin
			$display("%0t: unexpected beat read_data=%h video_page=%h audio_page=%h",
				$time, rd, vp, ap);
			mismatches++;
			return;
		end
		exp_beat = pending_pages.pop_front();
		if (rd !== exp_beat.read_data) begin
			$display("%0t: read_data expected %h actual %h", $time, exp_beat.read_data, rd);
			mismatches++;
		end
		if (vp !== exp_beat.video_page) begin
			$display("%0t: video_page expected %h actual %h", $time, exp_beat.video_page, vp);
			mismatches++;
		end
		if (ap !== exp_beat.audio_page) begin
			$display("%0t: audio_page expected %h actual %h", $time, exp_beat.audio_page, ap);
			mismatches++;
		end
	endfunction
endclass

module tb_bytebytejump_frame_engine_unit;
	import bbj_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	op_t op = OP_WRITE;
	logic [23:0] address = '0;
	logic [7:0] write_data = '0;
	logic [15:0] keys = '0;
	logic cfg_valid = 1'b0;
	logic [16:0] frame_len = '0;
	logic busy;
	logic cfg_ready;
	logic done;
	logic [7:0] read_data;
	logic [7:0] video_page;
	logic [15:0] audio_page;

	vm_page_tracker pages = new();
	bit idle_free = 1'b0;
	int unsigned ops_issued = 0;
	int unsigned op_count [4] = '{0, 0, 0, 0};
	int unsigned len_writes = 0;

	bytebytejump_frame_engine_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.address(address),
		.write_data(write_data),
		.keys(keys),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.instructions_per_frame(frame_len),
		.done(done),
		.read_data(read_data),
		.video_page(video_page),
		.audio_page(audio_page)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (done === 1'b1)
			pages.check_beat(read_data, video_page, audio_page);
	end

	initial begin
		#600_000_000;
		$display("[bytebytejump_frame_engine_unit] ERROR");
		$finish;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (idle_free)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(20, 200);
	endfunction

	function automatic bit [23:0] pick_src();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 24'($urandom_range(0, 63));
		if (r < 85)
			return 24'($urandom_range(0, 255));
		if (r < 95)
			return 24'($urandom());
		return 24'hFFFFFF - 24'($urandom_range(0, 7));
	endfunction

	function automatic bit [23:0] pick_dst();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 24'($urandom_range(5, 7));
		if (r < 90)
			return 24'($urandom_range(0, 63));
		return 24'($urandom());
	endfunction

	function automatic bit [16:0] pick_len();
		if ($urandom_range(0, 7) == 0)
			return 17'd0;
		return 17'($urandom_range(1, 8));
	endfunction

	// start stays high across back-to-back beats
	task automatic issue_op(op_t o, bit [23:0] a, bit [7:0] d, bit [15:0] k);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		address <= a;
		write_data <= d;
		keys <= k;
		do @(posedge clk); while (busy !== 1'b0);
		pages.note_op(o, a, d, k);
		op_count[o]++;
		ops_issued++;
	endtask

	task automatic issue_rand(op_t o, bit [23:0] a);
		issue_op(o, a, 8'($urandom()), 16'($urandom()));
	endtask

	task automatic write_frame_len(bit [16:0] v);
		start <= 1'b0;
		while (pages.pending_pages.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		frame_len <= v;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		pages.frame_len = v;
		len_writes++;
	endtask

	task automatic poke_word(bit [23:0] at, bit [23:0] w);
		issue_op(OP_WRITE, at, w[23:16], 16'($urandom()));
		issue_op(OP_WRITE, at + 24'd1, w[15:8], 16'($urandom()));
		issue_op(OP_WRITE, at + 24'd2, w[7:0], 16'($urandom()));
	endtask

	task automatic load_program();
		bit [23:0] base;
		bit [23:0] at;
		int unsigned n;
		base = 24'($urandom_range(8, 40));
		n = $urandom_range(1, 3);
		poke_word(24'd2, base);
		for (int unsigned i = 0; i < n; i++) begin
			at = base + 24'(9 * i);
			poke_word(at, pick_src());
			poke_word(at + 24'd3, pick_dst());
			poke_word(at + 24'd6, (i == n - 1) ? base : at + 24'd9);
		end
	endtask

	initial begin
		int unsigned r;
		int unsigned directed_ops;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: edges of memory and fields, no-op, empty frame
		write_frame_len(17'd0);
		issue_op(OP_READ, 24'h000000, 8'h00, 16'h0000);
		issue_op(OP_READ, 24'hFFFFFF, 8'h00, 16'h0000);
		issue_op(OP_WRITE, 24'hFFFFFF, 8'hFF, 16'hFFFF);
		issue_op(OP_READ, 24'hFFFFFF, 8'hFF, 16'hFFFF);
		issue_op(OP_WRITE, 24'd5, 8'hFF, 16'h0000);
		issue_op(OP_WRITE, 24'd6, 8'h80, 16'h0000);
		issue_op(OP_WRITE, 24'd7, 8'h01, 16'h0000);
		issue_op(OP_NOP, 24'hFFFFFF, 8'hFF, 16'hFFFF);
		issue_op(OP_FRAME, 24'h000000, 8'h00, 16'hFFFF);
		issue_op(OP_READ, 24'd0, 8'h00, 16'h0000);
		issue_op(OP_READ, 24'd1, 8'h00, 16'h0000);

		// one instruction with its words straddling the top of memory
		write_frame_len(17'd1);
		issue_op(OP_WRITE, 24'd2, 8'hFF, 16'h0000);
		issue_op(OP_WRITE, 24'd3, 8'hFF, 16'h0000);
		issue_op(OP_WRITE, 24'd4, 8'hFE, 16'h0000);
		issue_op(OP_WRITE, 24'h00FF00, 8'h5A, 16'h0000);
		issue_op(OP_FRAME, 24'h000000, 8'h00, 16'hA55A);
		issue_op(OP_READ, 24'd0, 8'h00, 16'h0000);
		issue_op(OP_WRITE, 24'h000000, 8'h00, 16'h0000);
		issue_op(OP_FRAME, 24'hFFFFFF, 8'hFF, 16'h0000);
		issue_op(OP_READ, 24'd0, 8'h00, 16'h0000);
		directed_ops = ops_issued;

		while (ops_issued < directed_ops + 75) begin
			r = $urandom_range(0, 9);
			idle_free = ($urandom_range(0, 3) == 0);
			if (r < 4) begin
				write_frame_len(pick_len());
				load_program();
				issue_rand(OP_FRAME, 24'($urandom()));
				issue_rand(OP_READ, 24'($urandom_range(0, 63)));
			end else if (r < 6) begin
				poke_word(24'($urandom_range(8, 60)), ($urandom_range(0, 1) == 1) ? pick_src() :
					pick_dst());
				issue_rand(OP_FRAME, 24'($urandom()));
			end else begin
				issue_rand(op_t'($urandom_range(0, 3)),
					($urandom_range(0, 1) == 1) ? 24'($urandom_range(0, 63)) : 24'($urandom()));
			end
		end
		idle_free = 1'b0;

		// full-length frame, then an over-range count that clamps
		write_frame_len(17'h10000);
		issue_rand(OP_FRAME, 24'($urandom()));
		write_frame_len(17'h1FFFF);
		issue_rand(OP_FRAME, 24'($urandom()));
		issue_rand(OP_READ, 24'($urandom_range(0, 7)));

		start <= 1'b0;
		while (pages.pending_pages.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Covered %0d writes, %0d reads, %0d no-ops, %0d frames (%0d instructions),",
			op_count[OP_WRITE], op_count[OP_READ], op_count[OP_NOP], op_count[OP_FRAME],
			pages.steps_run);
		$display("%0d length settings; %0d result beats checked, %0d mismatches.",
			len_writes, pages.beats, pages.mismatches);
		if (pages.mismatches == 0 && pages.pending_pages.size() == 0)
			$display("[bytebytejump_frame_engine_unit] OK");
		else
			$display("[bytebytejump_frame_engine_unit] ERROR");
		$finish;
	end
endmodule

/* bytebytejump_frame_engine_unit.f */
design/bbj_pkg.sv
design/bbj_ram.sv
design/bytebytejump_frame_engine_unit.sv
tb/sv/tb_bytebytejump_frame_engine_unit.sv
